FILE: design/scanline_polygon_span_fill_unit_macros.svh
// assertion helpers for the span fill unit
`ifndef SCANLINE_POLYGON_SPAN_FILL_UNIT_MACROS_SVH
`define SCANLINE_POLYGON_SPAN_FILL_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SPF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SPF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/spf_pkg.sv
package spf_pkg;

    localparam int MAX_SPANS = 8;
    localparam int SPAN_IW   = 3;
    localparam int SPAN_CW   = 4;

    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_FILL_RED      = 3'd2;
    localparam logic [2:0] CFG_FILL_GREEN    = 3'd3;
    localparam logic [2:0] CFG_FILL_BLUE     = 3'd4;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CHK   = 11'b000_0000_0010,
        S_PRIME = 11'b000_0000_0100,
        S_EDGE  = 11'b000_0000_1000,
        S_MUL   = 11'b000_0001_0000,
        S_DIV   = 11'b000_0010_0000,
        S_FIX   = 11'b000_0100_0000,
        S_INS   = 11'b000_1000_0000,
        S_NEXT  = 11'b001_0000_0000,
        S_SPAN  = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } spf_state_t;

endpackage

FILE: design/scanline_polygon_span_fill_unit.sv
// vertex word: taken while idle, ready again the next cycle
// row word: check and prime steps, then an edge and a next step per stored edge; each
//   crossing adds the shared multiply, bit-serial restoring divide, fix and insert steps,
//   then span steps, then one result word per cycle unless out_ready stalls it (8 at most)
// one row or vertex in flight at a time; the output register lets the next word in
// reset: registers to their reset values, polygon empty, box zero, output empty
`include "scanline_polygon_span_fill_unit_macros.svh"

module scanline_polygon_span_fill_unit #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic               first_vertex,
    input  logic signed [15:0] vertex_x,
    input  logic signed [15:0] vertex_y,
    input  logic [11:0]        row_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               span_valid,
    output logic [11:0]        row_index,
    output logic [12:0]        span_start,
    output logic [12:0]        span_end,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic               last
);
    import spf_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int W  = COORD_BITS + 1;
    localparam int XW = ((COORD_BITS > 14) ? COORD_BITS : 14) + 2;
    localparam int DW = $clog2(W);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_VERTICES);
    localparam logic [SPAN_CW-1:0] SPAN_CAP = SPAN_CW'(MAX_SPANS);

    spf_state_t state_reg, state_next;

    logic [12:0] sw_reg, sh_reg;
    logic [7:0]  red_cfg_reg, green_cfg_reg, blue_cfg_reg;

    logic [CW-1:0] count_reg;
    logic signed [CB-1:0] bminx_reg, bmaxx_reg, bminy_reg, bmaxy_reg;

    logic signed [CB-1:0] mem_x [MAX_VERTICES];
    logic signed [CB-1:0] mem_y [MAX_VERTICES];
    logic signed [CB-1:0] rd_x_reg, rd_y_reg, prev_x_reg, prev_y_reg;
    logic [IW-1:0] rd_addr, idx_reg, last_idx;

    logic [11:0] row_reg;
    logic signed [XW-1:0] left_reg, right_reg;

    logic [W-1:0] am_reg, mm_reg, d_reg, quo_reg, low_reg;
    logic [W:0]   rem_reg, d_ext, trial;
    logic         neg_reg, ge;
    logic [DW-1:0] dcnt_reg;
    logic [2*W-1:0] prod;

    logic signed [XW-1:0] node_new_reg;
    logic signed [XW-1:0] nodes_reg [MAX_VERTICES];
    logic signed [XW-1:0] nodes_ins [MAX_VERTICES];
    logic signed [XW-1:0] nodes_sh2 [MAX_VERTICES];
    logic signed [XW-1:0] nodes_prv [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] gt_vec, gtp_vec;
    logic [CW-1:0] n_reg;

    logic [12:0] span_s_reg [MAX_SPANS];
    logic [12:0] span_e_reg [MAX_SPANS];
    logic [SPAN_CW-1:0] ns_reg;
    logic [SPAN_IW-1:0] eidx_reg;

    logic        out_valid_reg, out_last_reg, out_sv_reg;
    logic [12:0] out_s_reg, out_e_reg;
    logic [7:0]  out_r_reg, out_g_reg, out_b_reg;
    logic [11:0] out_row_reg;

    logic in_acc, vtx_acc, row_acc, vtx_we;
    logic [CW-1:0] vcount;
    logic signed [CB-1:0] vx_c, vy_c;

    logic signed [XW-1:0] py, xi, yi, xj, yj, dx_s, d_s, a_s;
    logic signed [XW-1:0] bminx, bmaxx, bminy, bmaxy, sw_s, sh_s, top, bot;
    logic signed [XW-1:0] left_c, right_c, ipx, sum_p, sum_m, fix_val;
    logic signed [XW-1:0] pa, pb, ca, cb_s;
    logic crosses, row_in_box, rnz, pair_ok, span_keep;
    logic emit_load, emit_last;

    // input side
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign vtx_acc   = in_acc && !func;
    assign row_acc   = in_acc && func;
    assign vcount    = first_vertex ? '0 : count_reg;
    assign vtx_we    = vtx_acc && (vcount < MAX_COUNT);
    assign vx_c      = CB'(vertex_x);
    assign vy_c      = CB'(vertex_y);

    // scan geometry
    assign py    = XW'(row_reg);
    assign xi    = XW'(rd_x_reg);
    assign yi    = XW'(rd_y_reg);
    assign xj    = XW'(prev_x_reg);
    assign yj    = XW'(prev_y_reg);
    assign dx_s  = xj - xi;
    assign d_s   = yj - yi;
    assign a_s   = py - yi;
    assign crosses = ((yi < py) && !(yj < py)) || ((yj < py) && !(yi < py));

    assign bminx = XW'(bminx_reg);
    assign bmaxx = XW'(bmaxx_reg);
    assign bminy = XW'(bminy_reg);
    assign bmaxy = XW'(bmaxy_reg);
    assign sw_s  = XW'(sw_reg);
    assign sh_s  = XW'(sh_reg);
    assign top     = bminy[XW-1] ? '0 : bminy;
    assign bot     = (bmaxy < sh_s) ? bmaxy : sh_s;
    assign left_c  = bminx[XW-1] ? '0 : bminx;
    assign right_c = (bmaxx < sw_s) ? bmaxx : sw_s;
    assign row_in_box = !(py < top) && (py < bot) && (count_reg != '0);

    assign last_idx = IW'(count_reg - 1'b1);
    always_comb
    begin
        unique case (state_reg)
            S_CHK:   rd_addr = last_idx;
            S_NEXT:  rd_addr = idx_reg + 1'b1;
            default: rd_addr = idx_reg;
        endcase
    end

    // shared multiply and restoring divide
    assign prod  = am_reg * mm_reg;
    assign d_ext = {1'b0, d_reg};
    assign trial = {rem_reg[W-1:0], low_reg[W-1]};
    assign ge    = (trial >= d_ext);

    // truncate toward zero
    assign ipx   = XW'(quo_reg);
    assign sum_p = xi + ipx;
    assign sum_m = xi - ipx;
    assign rnz   = |rem_reg;
    always_comb
    begin
        if (!neg_reg)
        begin
            fix_val = (sum_p[XW-1] && rnz) ? sum_p + 1'b1 : sum_p;
        end
        else
        begin
            fix_val = (!sum_m[XW-1] && (sum_m != '0) && rnz) ? sum_m - 1'b1 : sum_m;
        end
    end

    // sorted insertion and pair shift
    always_comb
    begin
        for (int k = 0; k < MAX_VERTICES; k++)
        begin
            gt_vec[k] = (CW'(k) < n_reg) && (nodes_reg[k] > node_new_reg);
        end
        gtp_vec = {gt_vec[MAX_VERTICES-2:0], 1'b0};
        nodes_prv[0] = node_new_reg;
        for (int k = 1; k < MAX_VERTICES; k++)
        begin
            nodes_prv[k] = nodes_reg[k-1];
        end
        for (int k = 0; k < MAX_VERTICES; k++)
        begin
            if (gtp_vec[k])
                nodes_ins[k] = nodes_prv[k];
            else if (gt_vec[k] || (CW'(k) == n_reg))
                nodes_ins[k] = node_new_reg;
            else
                nodes_ins[k] = nodes_reg[k];
        end
        for (int k = 0; k < MAX_VERTICES - 2; k++)
        begin
            nodes_sh2[k] = nodes_reg[k+2];
        end
        nodes_sh2[MAX_VERTICES-2] = nodes_reg[MAX_VERTICES-2];
        nodes_sh2[MAX_VERTICES-1] = nodes_reg[MAX_VERTICES-1];
    end

    assign pa        = nodes_reg[0];
    assign pb        = nodes_reg[1];
    assign pair_ok   = (n_reg >= CW'(2)) && (ns_reg < SPAN_CAP);
    assign ca        = (pa < left_reg) ? left_reg : pa;
    assign cb_s      = (pb > right_reg) ? right_reg : pb;
    assign span_keep = (pb > left_reg) && (ca < cb_s);

    assign emit_load = !out_valid_reg || out_ready;
    assign emit_last = (ns_reg == '0) || (SPAN_CW'(eidx_reg) == ns_reg - 1'b1);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (row_acc) state_next = S_CHK;
            S_CHK:   state_next = row_in_box ? S_PRIME : S_EMIT;
            S_PRIME: state_next = S_EDGE;
            S_EDGE:  state_next = crosses ? S_MUL : S_NEXT;
            S_MUL:   state_next = S_DIV;
            S_DIV:   if (dcnt_reg == DW'(W - 1)) state_next = S_FIX;
            S_FIX:   state_next = S_INS;
            S_INS:   state_next = S_NEXT;
            S_NEXT:  state_next = (idx_reg == last_idx) ? S_SPAN : S_EDGE;
            S_SPAN:  if (!pair_ok || !(pa < right_reg)) state_next = S_EMIT;
            S_EMIT:  if (emit_load && emit_last) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sw_reg        <= 13'd640;
            sh_reg        <= 13'd480;
            red_cfg_reg   <= 8'd255;
            green_cfg_reg <= 8'd255;
            blue_cfg_reg  <= 8'd255;
            count_reg     <= '0;
            bminx_reg     <= '0;
            bmaxx_reg     <= '0;
            bminy_reg     <= '0;
            bmaxy_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            ns_reg        <= '0;
            eidx_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SCREEN_WIDTH:  sw_reg        <= cfg_data;
                    CFG_SCREEN_HEIGHT: sh_reg        <= cfg_data;
                    CFG_FILL_RED:      red_cfg_reg   <= cfg_data[7:0];
                    CFG_FILL_GREEN:    green_cfg_reg <= cfg_data[7:0];
                    CFG_FILL_BLUE:     blue_cfg_reg  <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (vtx_acc)
            begin
                count_reg <= vtx_we ? vcount + 1'b1 : vcount;
            end
            if (vtx_we)
            begin
                if (vcount == '0)
                begin
                    bminx_reg <= vx_c;
                    bmaxx_reg <= vx_c;
                    bminy_reg <= vy_c;
                    bmaxy_reg <= vy_c;
                end
                else
                begin
                    if (vx_c < bminx_reg) bminx_reg <= vx_c;
                    if (vx_c > bmaxx_reg) bmaxx_reg <= vx_c;
                    if (vy_c < bminy_reg) bminy_reg <= vy_c;
                    if (vy_c > bmaxy_reg) bmaxy_reg <= vy_c;
                end
            end
            if (row_acc)
            begin
                idx_reg  <= '0;
                n_reg    <= '0;
                ns_reg   <= '0;
                eidx_reg <= '0;
            end
            if (state_reg == S_MUL)
                dcnt_reg <= '0;
            if (state_reg == S_DIV)
                dcnt_reg <= dcnt_reg + 1'b1;
            if (state_reg == S_INS)
                n_reg <= n_reg + 1'b1;
            if ((state_reg == S_NEXT) && (idx_reg != last_idx))
                idx_reg <= idx_reg + 1'b1;
            if ((state_reg == S_SPAN) && pair_ok && (pa < right_reg))
            begin
                n_reg <= n_reg - CW'(2);
                if (span_keep)
                    ns_reg <= ns_reg + 1'b1;
            end
            if ((state_reg == S_EMIT) && emit_load)
            begin
                out_valid_reg <= 1'b1;
                eidx_reg      <= eidx_reg + 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // vertex store, registered read
    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            mem_x[vcount[IW-1:0]] <= vx_c;
            mem_y[vcount[IW-1:0]] <= vy_c;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (row_acc)
            row_reg <= row_y;
        if (state_reg == S_CHK)
        begin
            left_reg  <= left_c;
            right_reg <= right_c;
        end
        if ((state_reg == S_PRIME) || (state_reg == S_NEXT))
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        if (state_reg == S_EDGE)
        begin
            am_reg  <= W'(a_s[XW-1] ? -a_s : a_s);
            mm_reg  <= W'(dx_s[XW-1] ? -dx_s : dx_s);
            d_reg   <= W'(d_s[XW-1] ? -d_s : d_s);
            neg_reg <= dx_s[XW-1] ^ d_s[XW-1] ^ a_s[XW-1];
        end
        if (state_reg == S_MUL)
        begin
            rem_reg <= {1'b0, prod[2*W-1:W]};
            low_reg <= prod[W-1:0];
            quo_reg <= '0;
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= ge ? trial - d_ext : trial;
            low_reg <= {low_reg[W-2:0], 1'b0};
            quo_reg <= {quo_reg[W-2:0], ge};
        end
        if (state_reg == S_FIX)
            node_new_reg <= fix_val;
        if (state_reg == S_INS)
        begin
            for (int k = 0; k < MAX_VERTICES; k++)
                nodes_reg[k] <= nodes_ins[k];
        end
        if ((state_reg == S_SPAN) && pair_ok && (pa < right_reg))
        begin
            for (int k = 0; k < MAX_VERTICES; k++)
                nodes_reg[k] <= nodes_sh2[k];
            if (span_keep)
            begin
                span_s_reg[ns_reg[SPAN_IW-1:0]] <= ca[12:0];
                span_e_reg[ns_reg[SPAN_IW-1:0]] <= cb_s[12:0];
            end
        end
        if ((state_reg == S_EMIT) && emit_load)
        begin
            out_row_reg  <= row_reg;
            out_last_reg <= emit_last;
            if (ns_reg == '0)
            begin
                out_sv_reg <= 1'b0;
                out_s_reg  <= '0;
                out_e_reg  <= '0;
                out_r_reg  <= '0;
                out_g_reg  <= '0;
                out_b_reg  <= '0;
            end
            else
            begin
                out_sv_reg <= 1'b1;
                out_s_reg  <= span_s_reg[eidx_reg];
                out_e_reg  <= span_e_reg[eidx_reg];
                out_r_reg  <= red_cfg_reg;
                out_g_reg  <= green_cfg_reg;
                out_b_reg  <= blue_cfg_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign span_valid = out_sv_reg;
    assign row_index  = out_row_reg;
    assign span_start = out_s_reg;
    assign span_end   = out_e_reg;
    assign red        = out_r_reg;
    assign green      = out_g_reg;
    assign blue       = out_b_reg;
    assign last       = out_last_reg;

    `SPF_ASSERT_IMP(a_div_rem_below_divisor, state_reg == S_DIV, rem_reg < d_ext,
        "divider remainder not below divisor")
    `SPF_ASSERT_NEXT(a_vertex_append, vtx_acc && !first_vertex && (count_reg < MAX_COUNT),
        count_reg == CW'($past(count_reg) + 1'b1), "vertex count did not advance")
    `SPF_ASSERT_IMP(a_counts_bounded, 1'b1,
        (count_reg <= MAX_COUNT) && (n_reg <= MAX_COUNT) && (ns_reg <= SPAN_CAP),
        "crossing or span count out of range")
    `SPF_ASSERT_NEXT(a_last_to_idle, (state_reg == S_EMIT) && emit_load && emit_last,
        (state_reg == S_IDLE) && out_valid_reg && out_last_reg,
        "row did not close on last word")

endmodule

FILE: test/testbench.sv
module testbench;
    import spf_pkg::*;

    localparam int VERTEX_CAP = 16;
    localparam int ROW_SETTLE = 600;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic        span_valid;
        logic [11:0] row_index;
        logic [12:0] span_start;
        logic [12:0] span_end;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
    } span_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [12:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = 1'b0;
    logic               first_vertex = 1'b0;
    logic signed [15:0] vertex_x = '0;
    logic signed [15:0] vertex_y = '0;
    logic [11:0]        row_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               span_valid;
    logic [11:0]        row_index;
    logic [12:0]        span_start;
    logic [12:0]        span_end;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last;

    scanline_polygon_span_fill_unit DUT (.*);

    // shadow of block state
    longint      poly_x [VERTEX_CAP];
    longint      poly_y [VERTEX_CAP];
    int          poly_count = 0;
    longint      bmin_x = 0, bmax_x = 0, bmin_y = 0, bmax_y = 0;
    logic [12:0] scr_w = 13'd640, scr_h = 13'd480;
    logic [7:0]  col_r = 8'd255, col_g = 8'd255, col_b = 8'd255;

    span_word_t  pending_spans [$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic void load_vertex(input logic first, input logic signed [15:0] x,
                                        input logic signed [15:0] y);
        if (first)
            poly_count = 0;
        if (poly_count >= VERTEX_CAP)
            return;
        poly_x[poly_count] = longint'(x);
        poly_y[poly_count] = longint'(y);
        if (poly_count == 0) begin
            bmin_x = longint'(x);
            bmax_x = longint'(x);
            bmin_y = longint'(y);
            bmax_y = longint'(y);
        end
        else begin
            if (longint'(x) < bmin_x) bmin_x = longint'(x);
            if (longint'(x) > bmax_x) bmax_x = longint'(x);
            if (longint'(y) < bmin_y) bmin_y = longint'(y);
            if (longint'(y) > bmax_y) bmax_y = longint'(y);
        end
        poly_count++;
    endfunction

    function automatic void predict_spans(input logic [11:0] row);
        longint     crossings [VERTEX_CAP];
        longint     s_lo [8];
        longint     s_hi [8];
        longint     lft, rgt, top, bot, py, d, num, v, a, b, yi, yj;
        int         n, ns, j, k;
        span_word_t w;
        n = 0;
        ns = 0;
        py = longint'(row);
        lft = bmin_x > 0 ? bmin_x : 0;
        rgt = bmax_x < longint'(scr_w) ? bmax_x : longint'(scr_w);
        top = bmin_y > 0 ? bmin_y : 0;
        bot = bmax_y < longint'(scr_h) ? bmax_y : longint'(scr_h);
        if (py >= top && py < bot && poly_count > 0) begin
            j = poly_count - 1;
            for (int i = 0; i < poly_count; i++) begin
                yi = poly_y[i];
                yj = poly_y[j];
                if ((yi < py && yj >= py) || (yj < py && yi >= py)) begin
                    d = yj - yi;
                    num = poly_x[i] * d + (py - yi) * (poly_x[j] - poly_x[i]);
                    if (d < 0) begin
                        d = -d;
                        num = -num;
                    end
                    crossings[n] = num / d;
                    n++;
                end
                j = i;
            end
            for (int i = 1; i < n; i++) begin
                v = crossings[i];
                k = i;
                while (k > 0 && crossings[k - 1] > v) begin
                    crossings[k] = crossings[k - 1];
                    k--;
                end
                crossings[k] = v;
            end
            for (int i = 0; i + 1 < n && ns < 8; i += 2) begin
                a = crossings[i];
                b = crossings[i + 1];
                if (a >= rgt)
                    break;
                if (b > lft) begin
                    if (a < lft) a = lft;
                    if (b > rgt) b = rgt;
                    if (a < b) begin
                        s_lo[ns] = a;
                        s_hi[ns] = b;
                        ns++;
                    end
                end
            end
        end
        if (ns == 0) begin
            w = '0;
            w.row_index = row;
            w.last = 1'b1;
            pending_spans.push_back(w);
        end
        for (int i = 0; i < ns; i++) begin
            w.span_valid = 1'b1;
            w.row_index = row;
            w.span_start = s_lo[i][12:0];
            w.span_end = s_hi[i][12:0];
            w.red = col_r;
            w.green = col_g;
            w.blue = col_b;
            w.last = (i + 1 == ns);
            pending_spans.push_back(w);
        end
    endfunction

    // result side
    initial begin
        int k;
        forever begin
            k = calm ? 0 : $urandom_range(0, 10);
            if (k > 0) begin
                out_ready <= 1'b0;
                repeat (k) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk) begin
        span_word_t w;
        if (rst_n && out_valid && out_ready) begin
            if (pending_spans.size() == 0)
                report("result word with nothing expected");
            else begin
                w = pending_spans.pop_front();
                check_field("span_valid", span_valid, w.span_valid);
                check_field("row_index", row_index, w.row_index);
                check_field("span_start", span_start, w.span_start);
                check_field("span_end", span_end, w.span_end);
                check_field("red", red, w.red);
                check_field("green", green, w.green);
                check_field("blue", blue, w.blue);
                check_field("last", last, w.last);
            end
        end
    end

    task automatic send_word(input logic f, input logic first, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic [11:0] row);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func <= f;
        first_vertex <= first;
        vertex_x <= x;
        vertex_y <= y;
        row_y <= row;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        if (f)
            predict_spans(row);
        else
            load_vertex(first, x, y);
    endtask

    task automatic send_vertex(input logic first, input int x, input int y);
        send_word(1'b0, first, 16'(x), 16'(y), 12'($urandom));
    endtask

    task automatic send_row(input int row);
        send_word(1'b1, 1'($urandom), 16'($urandom), 16'($urandom), 12'(row));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_spans.size() != 0);
        repeat (ROW_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_SCREEN_WIDTH:  scr_w = data;
            CFG_SCREEN_HEIGHT: scr_h = data;
            CFG_FILL_RED:      col_r = data[7:0];
            CFG_FILL_GREEN:    col_g = data[7:0];
            CFG_FILL_BLUE:     col_b = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_screen(input int w, input int h, input int r, input int g, input int b);
        wait_idle();
        write_reg(CFG_SCREEN_WIDTH, 13'(w));
        write_reg(CFG_SCREEN_HEIGHT, 13'(h));
        write_reg(CFG_FILL_RED, 13'(r));
        write_reg(CFG_FILL_GREEN, 13'(g));
        write_reg(CFG_FILL_BLUE, 13'(b));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_polygon();
        send_row(0);
        send_row(100);
        send_row(4095);
    endtask

    task automatic test_shapes();
        // square, clipped on the left and top
        send_vertex(1'b1, -20, -10);
        send_vertex(1'b0, 50, -10);
        send_vertex(1'b0, 50, 40);
        send_vertex(1'b0, -20, 40);
        send_row(0);
        send_row(39);
        send_row(40);
        // triangle with sloped edges, past the right side
        send_vertex(1'b1, 600, 10);
        send_vertex(1'b0, 700, 90);
        send_vertex(1'b0, 550, 70);
        send_row(10);
        send_row(50);
        send_row(75);
        // extreme coordinates
        send_vertex(1'b1, -32768, -32768);
        send_vertex(1'b0, 32767, 0);
        send_vertex(1'b0, 0, 32767);
        send_row(1);
        send_row(479);
        // comb with sixteen vertices, extra vertices ignored
        for (int i = 0; i < 8; i++) begin
            send_vertex(i == 0, 20 + 40 * i, 5);
            send_vertex(1'b0, 40 + 40 * i, 100);
        end
        send_vertex(1'b0, 5, 5);
        send_vertex(1'b0, 630, 300);
        send_row(50);
        send_row(99);
    endtask

    task automatic test_random(input int budget);
        int n, lo, hi, rows, sent;
        bit wide;
        sent = 0;
        while (sent < budget) begin
            if (($urandom_range(0, 7)) == 0)
                calm = ~calm;
            wide = ($urandom_range(0, 5) == 0);
            n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 20) : $urandom_range(3, 10);
            for (int i = 0; i < n; i++) begin
                if (wide)
                    send_vertex(i == 0, $signed(16'($urandom)), $signed(16'($urandom)));
                else
                    send_vertex(i == 0 || $urandom_range(0, 30) == 0,
                                $urandom_range(0, 760) - 60, $urandom_range(0, 560) - 40);
                sent++;
            end
            rows = $urandom_range(1, 4);
            lo = int'(bmin_y < 0 ? 0 : (bmin_y > 4095 ? 4095 : bmin_y));
            hi = int'(bmax_y > 4095 ? 4095 : (bmax_y < lo ? longint'(lo) : bmax_y));
            for (int i = 0; i < rows; i++) begin
                if ($urandom_range(0, 5) == 0)
                    send_row($urandom_range(0, 4095));
                else
                    send_row($urandom_range(lo, hi));
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_polygon();
        test_shapes();
        set_screen(4096, 4096, 0, 0, 0);
        test_shapes();
        set_screen(1, 1, 255, 0, 255);
        test_shapes();
        set_screen(640, 480, 18, 200, 7);
        test_random(90);
        // let everything drain before going on
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_spans.size() != 0);
        test_random(80);
        set_screen(200, 150, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
        test_random(60);
        set_screen(4096, 4096, 255, 255, 255);
        test_random(40);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_spans.size() != 0);
        repeat (ROW_SETTLE) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
